@@ sv/ise_pkg.sv @@
// Shared types and constants for the interpolation search engine.
// No dependencies; every module of the block imports this package.
`default_nettype none
package ise_pkg;

  // Default geometry of the sorted store
  localparam int ISE_DEPTH      = 1024;
  localparam int ISE_DATA_WIDTH = 32;

  // Fixed port field widths
  localparam int ISE_IDX_W  = 10;
  localparam int ISE_WORD_W = 32;
  localparam int ISE_CNT_W  = 11;

  // Request codes
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // Store read address source
  typedef enum logic [1:0] {
    RSEL_LOW,
    RSEL_HIGH,
    RSEL_MID
  } ise_rsel_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_CAP_HI,
    ST_EVAL,
    ST_DIV_DBL,
    ST_DIV_ADD,
    ST_PROBE_RD,
    ST_PROBE_CMP,
    ST_RESULT
  } ise_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic      mem_we;      // write the accepted entry beat into the store
    logic      start;       // latch key, set up the search range
    ise_rsel_t rsel;        // store read address select
    logic      cap_vl;      // capture value at low
    logic      cap_vh;      // capture value at high
    logic      div_init;    // load the scaled quotient unit
    logic      div_dbl;     // doubling half of one quotient step
    logic      div_add;     // conditional add half of one quotient step
    logic      set_lo_hit;  // final compare at low
    logic      set_mid_hit; // probe matched
    logic      narrow_hi;   // high <= mid - 1
    logic      narrow_lo;   // low <= mid + 1
    logic      load_out;    // move the result into the output register
  } ise_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic cnt_zero;  // no entries in use
    logic exit_loop; // end values equal or key outside them
    logic vm_eq;     // probed value equals key
    logic vm_gt;     // probed value above key
  } ise_sts_t;

endpackage
`default_nettype wire

@@ sv/ise_dpath.sv @@
// Datapath of the interpolation search engine: sorted store, range
// registers, bit-serial scaled quotient unit and output register. Uses ise_pkg.
`default_nettype none
module ise_dpath #(
  parameter int DEPTH      = ise_pkg::ISE_DEPTH,
  parameter int DATA_WIDTH = ise_pkg::ISE_DATA_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [ise_pkg::ISE_IDX_W-1:0]  in_entry_index,
  input  wire logic [ise_pkg::ISE_WORD_W-1:0] in_word_value,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ise_pkg::ISE_CNT_W-1:0]  cfg_wr_data,
  input  wire ise_pkg::ise_cmd_t              cmd,
  output ise_pkg::ise_sts_t                   sts,
  output logic                                out_found,
  output logic [ise_pkg::ISE_IDX_W-1:0]       out_position
);
  import ise_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DW = DATA_WIDTH;

  logic [DW-1:0]        mem [DEPTH];
  logic [DW-1:0]        rdata_r;
  logic [AW-1:0]        raddr;
  logic [ISE_CNT_W-1:0] elem_count_r;

  logic [DW-1:0] key_r;
  logic [DW-1:0] vl_r;
  logic [DW-1:0] vh_r;
  logic [AW-1:0] low_r;
  logic [AW-1:0] high_r;
  logic [AW-1:0] mid_r;
  logic          hit_r;
  logic [AW-1:0] where_r;

  logic [DW-1:0] n_r;
  logic [DW-1:0] d_r;
  logic [DW-1:0] rem_r;
  logic [AW-1:0] m_r;
  logic [AW-1:0] q_r;

  logic          wr_ok;
  logic          cnt_over;
  logic [AW-1:0] high_init;
  logic [AW-1:0] mid_calc;
  logic [DW:0]   dbl_sum;
  logic          dbl_ge;
  logic [DW:0]   add_sum;
  logic          add_ge;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elem_count_r <= '0;
    end else if (cfg_wr_en) begin
      elem_count_r <= cfg_wr_data;
    end
  end

  // Store write port: drop beats addressed beyond the store
  assign wr_ok = 32'(in_entry_index) < 32'(DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.mem_we && wr_ok) begin
      mem[AW'(in_entry_index)] <= DW'(in_word_value);
    end
  end

  // Store read port with registered data
  assign mid_calc = low_r + q_r;

  always_comb begin
    case (cmd.rsel)
      RSEL_LOW:  raddr = low_r;
      RSEL_HIGH: raddr = high_r;
      RSEL_MID:  raddr = mid_calc;
      default:   raddr = low_r;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  // Saturate the count to the store depth
  assign cnt_over  = 32'(elem_count_r) > 32'(DEPTH);
  assign high_init = cnt_over ? AW'(DEPTH - 1) : AW'(elem_count_r - 1'b1);

  // Quotient step arithmetic: remainder stays below d
  assign dbl_sum = {rem_r, 1'b0};
  assign dbl_ge  = dbl_sum >= {1'b0, d_r};
  assign add_sum = {1'b0, rem_r} + {1'b0, n_r};
  assign add_ge  = add_sum >= {1'b0, d_r};

  // Search range, captured values and quotient unit
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r   <= DW'(in_word_value);
      low_r   <= '0;
      high_r  <= high_init;
      hit_r   <= 1'b0;
      where_r <= '0;
    end
    if (cmd.cap_vl) begin
      vl_r <= rdata_r;
    end
    if (cmd.cap_vh) begin
      vh_r <= rdata_r;
    end
    if (cmd.div_init) begin
      n_r   <= key_r - vl_r;
      d_r   <= vh_r - vl_r;
      m_r   <= high_r - low_r;
      rem_r <= '0;
      q_r   <= '0;
    end
    if (cmd.div_dbl) begin
      rem_r <= dbl_ge ? DW'(dbl_sum - {1'b0, d_r}) : DW'(dbl_sum);
      q_r   <= AW'({q_r, dbl_ge});
    end
    if (cmd.div_add) begin
      m_r <= AW'({m_r, 1'b0});
      if (m_r[AW-1]) begin
        rem_r <= add_ge ? DW'(add_sum - {1'b0, d_r}) : DW'(add_sum);
        q_r   <= q_r + AW'(add_ge);
      end
    end
    if (cmd.rsel == RSEL_MID) begin
      mid_r <= mid_calc;
    end
    if (cmd.narrow_hi) begin
      high_r <= mid_r - 1'b1;
    end
    if (cmd.narrow_lo) begin
      low_r <= mid_r + 1'b1;
    end
    if (cmd.set_lo_hit) begin
      hit_r   <= vl_r == key_r;
      where_r <= (vl_r == key_r) ? low_r : '0;
    end
    if (cmd.set_mid_hit) begin
      hit_r   <= 1'b1;
      where_r <= mid_r;
    end
    if (cmd.load_out) begin
      out_found    <= hit_r;
      out_position <= ISE_IDX_W'(where_r);
    end
  end

  // Status back to the controller
  assign sts.cnt_zero  = elem_count_r == '0;
  assign sts.exit_loop = (vh_r == vl_r) || (key_r < vl_r) || (key_r > vh_r);
  assign sts.vm_eq     = rdata_r == key_r;
  assign sts.vm_gt     = rdata_r > key_r;

endmodule
`default_nettype wire

@@ sv/ise_ctrl.sv @@
// Controller of the interpolation search engine: state machine, quotient
// step counter and output valid flag. Uses ise_pkg.
`default_nettype none
module ise_ctrl #(
  parameter int DEPTH = ise_pkg::ISE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_req_type,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire ise_pkg::ise_sts_t sts,
  output ise_pkg::ise_cmd_t      cmd
);
  import ise_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW = (AW > 1) ? $clog2(AW) : 1;

  ise_state_t    state_r;
  ise_state_t    state_nxt;
  logic [BW-1:0] bit_r;
  logic [BW-1:0] bit_nxt;
  logic          out_valid_r;
  logic          out_valid_nxt;
  logic          accept;

  assign in_ready  = state_r == ST_IDLE;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  // State, step counter and output flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_r       <= bit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    bit_nxt       = bit_r;
    cmd           = '0;
    cmd.rsel      = RSEL_LOW;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_req_type == REQ_WRITE) begin
            cmd.mem_we = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = sts.cnt_zero ? ST_RESULT : ST_RD_LO;
          end
        end
      end
      ST_RD_LO: begin
        cmd.rsel  = RSEL_LOW;
        state_nxt = ST_RD_HI;
      end
      ST_RD_HI: begin
        cmd.rsel   = RSEL_HIGH;
        cmd.cap_vl = 1'b1;
        state_nxt  = ST_CAP_HI;
      end
      ST_CAP_HI: begin
        cmd.cap_vh = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts.exit_loop) begin
          cmd.set_lo_hit = 1'b1;
          state_nxt      = ST_RESULT;
        end else begin
          cmd.div_init = 1'b1;
          bit_nxt      = BW'(AW - 1);
          state_nxt    = ST_DIV_DBL;
        end
      end
      ST_DIV_DBL: begin
        cmd.div_dbl = 1'b1;
        state_nxt   = ST_DIV_ADD;
      end
      ST_DIV_ADD: begin
        cmd.div_add = 1'b1;
        if (bit_r == '0) begin
          state_nxt = ST_PROBE_RD;
        end else begin
          bit_nxt   = bit_r - 1'b1;
          state_nxt = ST_DIV_DBL;
        end
      end
      ST_PROBE_RD: begin
        cmd.rsel  = RSEL_MID;
        state_nxt = ST_PROBE_CMP;
      end
      ST_PROBE_CMP: begin
        if (sts.vm_eq) begin
          cmd.set_mid_hit = 1'b1;
          state_nxt       = ST_RESULT;
        end else begin
          cmd.narrow_hi = sts.vm_gt;
          cmd.narrow_lo = !sts.vm_gt;
          state_nxt     = ST_RD_LO;
        end
      end
      ST_RESULT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ sv/interpolation_search_engine_unit.sv @@
// Interpolation search engine. A write beat (req_type 0) stores word_value
// at entry_index; indexes at or beyond DEPTH are dropped. A search beat
// (req_type 1) looks for word_value among entries 0 to elem_count-1 (capped
// at DEPTH), which must have been loaded in ascending order, and returns one
// result beat with found and position. The input side takes a new beat only
// when the engine is idle, but a finished result waits in its own output
// register, so the next beat may enter meanwhile. A search with a zero count
// goes straight to the result state. Otherwise each probe reads and checks
// the range end values through the single store read port, runs the
// bit-serial scaled quotient unit, a doubling and a conditional add step per
// bit, to compute the interpolated position, and then reads and compares the
// probed entry. A search that stops on a probe match then loads its result;
// one that stops on the range check first re-reads the range end values and
// then loads the result. The result load also waits while the previous
// result is still held in the output register. On evenly spread data a
// search usually needs only a few probes; on skewed or unordered data each
// probe narrows the range by at least one entry, so a search can take up to
// elem_count probes.
`default_nettype none
module interpolation_search_engine_unit #(
  parameter int DEPTH      = ise_pkg::ISE_DEPTH,
  parameter int DATA_WIDTH = ise_pkg::ISE_DATA_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_req_type,
  input  wire logic [ise_pkg::ISE_IDX_W-1:0]  in_entry_index,
  input  wire logic [ise_pkg::ISE_WORD_W-1:0] in_word_value,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_found,
  output logic [ise_pkg::ISE_IDX_W-1:0]       out_position,
  input  wire logic                           cfg_wr_en,
  input  wire logic [ise_pkg::ISE_CNT_W-1:0]  cfg_wr_data
);
  import ise_pkg::*;

  ise_cmd_t cmd;
  ise_sts_t sts;

  // Sequencer
  ise_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  // Store and arithmetic
  ise_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_entry_index (in_entry_index),
    .in_word_value  (in_word_value),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .cmd            (cmd),
    .sts            (sts),
    .out_found      (out_found),
    .out_position   (out_position)
  );

endmodule
`default_nettype wire

@@ verif/interpolation_search_engine_unit_tb.sv @@
// Self-checking testbench for interpolation_search_engine_unit: loads sorted
// and unsorted tables, searches them and checks every answer against its own
// mirror of the store. Depends on ise_pkg and the engine RTL only.
`timescale 1ns / 100ps
module interpolation_search_engine_unit_tb;
  import ise_pkg::*;

  localparam int CLK_HALF    = 6;
  localparam int STALL_LIMIT = 100000;
  localparam int PRINT_LIMIT = 40;

  // Shapes of table content used by the loader
  typedef enum int {
    SHAPE_SPREAD,
    SHAPE_DENSE,
    SHAPE_SKEWED,
    SHAPE_FULL_SPAN,
    SHAPE_SHUFFLED
  } table_shape_t;

  typedef struct packed {
    logic                 found;
    logic [ISE_IDX_W-1:0] position;
  } lookup_answer_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_req_type;
  logic [ISE_IDX_W-1:0]  in_entry_index;
  logic [ISE_WORD_W-1:0] in_word_value;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_found;
  logic [ISE_IDX_W-1:0]  out_position;
  logic                  cfg_wr_en;
  logic [ISE_CNT_W-1:0]  cfg_wr_data;

  // Mirror of the store and of the count register
  logic [ISE_WORD_W-1:0] mirror_table [ISE_DEPTH];
  int                    mirror_count = 0;
  lookup_answer_t        pending_lookups [$];

  int mismatch_count = 0;
  int snd_idle_pct   = 0;
  int rcv_idle_pct   = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int stall_cycles   = 0;

  interpolation_search_engine_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_word_value  (in_word_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_position   (out_position),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  always #CLK_HALF clk = ~clk;

  // Expected answer of one search over the mirrored table
  function automatic lookup_answer_t predict_lookup(input logic [ISE_WORD_W-1:0] key);
    lookup_answer_t ans;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    logic [63:0]    vl;
    logic [63:0]    vh;
    logic [63:0]    vm;
    logic [63:0]    span;
    ans.found    = 1'b0;
    ans.position = '0;
    if (mirror_count == 0) return ans;
    lo = 0;
    hi = mirror_count - 1;
    while (1) begin
      vl = 64'(mirror_table[lo]);
      vh = 64'(mirror_table[hi]);
      if (vh == vl || 64'(key) < vl || 64'(key) > vh) break;
      // exact product, no truncation
      span = (64'(key) - vl) * 64'(hi - lo);
      mid  = lo + 32'(span / (vh - vl));
      vm   = 64'(mirror_table[mid]);
      if (64'(key) == vm) begin
        ans.found    = 1'b1;
        ans.position = mid[ISE_IDX_W-1:0];
        return ans;
      end else if (64'(key) < vm) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    if (mirror_table[lo] == key) begin
      ans.found    = 1'b1;
      ans.position = lo[ISE_IDX_W-1:0];
    end
    return ans;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Offer one beat, hold it until accepted, then update the mirror
  task automatic send_beat(input logic req, input logic [ISE_IDX_W-1:0] idx,
                           input logic [ISE_WORD_W-1:0] word);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_entry_index <= idx;
    in_word_value  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (req == REQ_WRITE) mirror_table[idx] = word;
    else pending_lookups.push_back(predict_lookup(word));
  endtask

  task automatic write_entry(input logic [ISE_IDX_W-1:0] idx, input logic [ISE_WORD_W-1:0] word);
    send_beat(REQ_WRITE, idx, word);
  endtask

  // Index field is don't-care on a search, so randomise it
  task automatic search_key(input logic [ISE_WORD_W-1:0] key);
    send_beat(REQ_SEARCH, ISE_IDX_W'($urandom_range(0, ISE_DEPTH - 1)), key);
  endtask

  // Stop offering, wait for every answer, then let a trailing write settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_count(input int n);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= ISE_CNT_W'(n);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mirror_count = (n > ISE_DEPTH) ? ISE_DEPTH : n;
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct = snd;
    rcv_idle_pct = rcv;
  endtask

  // Fill entries 0..n-1 with content of the given shape
  task automatic load_table(input int n, input table_shape_t shape);
    logic [32:0] acc;
    logic [31:0] step_cap;
    int          i;
    step_cap = 32'hFFFF_FFFF / (n + 1);
    acc = (shape == SHAPE_FULL_SPAN) ? 33'd0 : 33'($urandom_range(0, step_cap));
    for (i = 0; i < n; i++) begin
      if (shape == SHAPE_FULL_SPAN && i == n - 1) acc = 33'h0_FFFF_FFFF;
      if (shape == SHAPE_SHUFFLED) acc = 33'($urandom());
      write_entry(ISE_IDX_W'(i), acc[31:0]);
      case (shape)
        SHAPE_DENSE: begin
          acc = acc + $urandom_range(0, 2);
        end
        SHAPE_SKEWED: begin
          acc = acc + $urandom_range(0, 1 << $urandom_range(0, 26));
        end
        default: begin
          acc = acc + $urandom_range(0, step_cap);
        end
      endcase
      // saturate so the table stays ascending
      if (acc[32]) acc = 33'h0_FFFF_FFFF;
    end
  endtask

  // Zero count, single entry, duplicates, word extremes, unsorted store
  task automatic test_directed();
    search_key(32'h0);
    search_key(32'hFFFF_FFFF);
    write_entry(0, 32'h0);
    write_entry(1, 32'd5);
    write_entry(2, 32'd5);
    write_entry(3, 32'd100);
    write_entry(4, 32'hFFFF_FFFF);
    write_entry(ISE_IDX_W'(ISE_DEPTH - 1), 32'd12345);
    set_count(1);
    search_key(32'h0);
    search_key(32'd7);
    set_count(5);
    search_key(32'h0);
    search_key(32'd5);
    search_key(32'd100);
    search_key(32'hFFFF_FFFF);
    search_key(32'd50);
    search_key(32'd6);
    set_count(0);
    search_key(32'd5);
    // break the ordering and search again
    write_entry(2, 32'd1);
    set_count(5);
    search_key(32'd1);
    search_key(32'd100);
    search_key(32'd3);
  endtask

  // Random tables of random size and shape, searched with keys of which half are taken from the table
  task automatic test_random_sweep(input int n_ops);
    int                    done;
    int                    n;
    int                    ops;
    int                    pick;
    table_shape_t          shape;
    logic [ISE_WORD_W-1:0] key;
    done = 0;
    while (done < n_ops) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) n = 0;
      else if (pick == 1) n = 1;
      else if (pick < 8) n = $urandom_range(2, 32);
      else n = $urandom_range(33, 128);
      pick = $urandom_range(0, 9);
      if (pick < 2) shape = SHAPE_DENSE;
      else if (pick < 6) shape = SHAPE_SPREAD;
      else if (pick == 6) shape = SHAPE_FULL_SPAN;
      else if (pick < 9) shape = SHAPE_SKEWED;
      else shape = SHAPE_SHUFFLED;
      load_table(n, shape);
      set_count(n);
      ops = $urandom_range(15, 40);
      while (ops > 0 && done < n_ops) begin
        ops--;
        done++;
        if ($urandom_range(0, 99) < 10) begin
          // stray write, may break the ordering
          write_entry(ISE_IDX_W'($urandom_range(0, ISE_DEPTH - 1)), $urandom());
        end else if (n == 0) begin
          search_key($urandom());
        end else begin
          pick = $urandom_range(0, 99);
          key  = mirror_table[$urandom_range(0, n - 1)];
          if (pick >= 50 && pick < 65) key = ($urandom_range(0, 1) != 0) ? key + 1 : key - 1;
          else if (pick >= 65 && pick < 90) key = $urandom();
          else if (pick >= 90) key = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
          search_key(key);
        end
      end
    end
  endtask

  // Whole store in range, count above the depth saturates. Only the range
  // ends and six randomly placed entries in line with them are loaded; each
  // key lands exactly on a loaded entry at the first probe or leaves the range at once.
  task automatic test_full_table();
    int                    i;
    int                    pos [6];
    logic [ISE_WORD_W-1:0] step;
    logic [ISE_WORD_W-1:0] top;
    step = 32'hFFFF_FFFF / ISE_DEPTH;
    top  = ISE_WORD_W'(ISE_DEPTH - 1) * step;
    write_entry(0, 32'h0);
    write_entry(ISE_IDX_W'(ISE_DEPTH - 1), top);
    for (i = 0; i < 6; i++) begin
      pos[i] = $urandom_range(1, ISE_DEPTH - 2);
      write_entry(ISE_IDX_W'(pos[i]), ISE_WORD_W'(pos[i]) * step);
    end
    set_count(2047);
    search_key(32'h0);
    search_key(top);
    search_key(top + 1);
    for (i = 0; i < 6; i++) search_key(ISE_WORD_W'(pos[i]) * step);
    set_count(ISE_DEPTH);
    for (i = 0; i < 3; i++) search_key(ISE_WORD_W'(pos[i]) * step);
    search_key(32'hFFFF_FFFF);
  endtask

  // Hold the result side off so the engine backs up into its input
  task automatic test_backpressure();
    int i;
    load_table(16, SHAPE_SPREAD);
    set_count(16);
    hold_request = 400;
    for (i = 0; i < 8; i++) search_key(mirror_table[$urandom_range(0, 15)]);
    wait_drained();
  endtask

  // Result side readiness, with an occasional long hold-off
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Check each result beat against the oldest pending answer
  always @(posedge clk) begin
    lookup_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b position=%0d",
                                  out_found, out_position));
      end else begin
        want = pending_lookups.pop_front();
        if (out_found !== want.found || out_position !== want.position)
          report_mismatch($sformatf("found=%0b position=%0d, want found=%0b position=%0d",
                                    out_found, out_position, want.found, want.position));
      end
    end
  end

  // Count cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = REQ_WRITE;
    in_entry_index = '0;
    in_word_value  = '0;
    out_ready      = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    set_idling(8, 80);
    test_directed();
    test_random_sweep(80);
    set_idling(80, 8);
    test_random_sweep(80);
    test_full_table();
    set_idling(0, 0);
    test_backpressure();
    test_random_sweep(80);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ interpolation_search_engine_unit.f @@
sv/ise_pkg.sv
sv/ise_dpath.sv
sv/ise_ctrl.sv
sv/interpolation_search_engine_unit.sv
verif/interpolation_search_engine_unit_tb.sv
